// ----- rtl/bba_pkg.sv -----
package bba_pkg;

  localparam int unsigned ByteW = 64;

  localparam logic [ByteW-1:0] AllOnes = '1;
  localparam logic [ByteW-1:0] LimitReset = 64'd1073741824;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RESIZE  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CANCEL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_WAIT      = 2'd1,
    ST_CANCELLED = 2'd2
  } status_e;

endpackage

// ----- rtl/bba_if.sv -----
interface bba_req_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [ByteW-1:0] amount;
  logic [ByteW-1:0] held_bytes;
  logic             held_overage;
  logic             allow_overage;

  modport source (
    output valid, op, amount, held_bytes, held_overage, allow_overage,
    input  ready
  );
  modport sink (
    input  valid, op, amount, held_bytes, held_overage, allow_overage,
    output ready
  );
endinterface

interface bba_rsp_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ByteW-1:0] new_bytes;
  logic             new_overage;
  logic [ByteW-1:0] total_bytes;
  logic [ByteW-1:0] peak_total;

  modport source (
    output valid, status, new_bytes, new_overage, total_bytes, peak_total,
    input  ready
  );
  modport sink (
    input  valid, status, new_bytes, new_overage, total_bytes, peak_total,
    output ready
  );
endinterface

// ----- rtl/byte_budget_admission.sv -----
// Byte budget admission: takes one acquire, resize, release or cancel request per
// transfer and returns one result per request, in order. A request is captured
// in an input register (where the resize delta and its direction are formed),
// then evaluated against the running 65-bit total, the overage flag and the
// limit, writing the result register and the budget state together, so a
// result passes the input register and then the result register. A new request
// is taken every cycle while the result side is ready (a stalled result holds
// the input register); throughput is one request per cycle under that condition,
// set by the single update of the total. A result of WAIT leaves the state
// untouched and the requester retries. The limit is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while no request is in flight (the block does not enforce this); it resets to 1 GiB.
module byte_budget_admission (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::ByteW-1:0] cfg_wdata_i,
  bba_req_if.sink                   req_i,
  bba_rsp_if.source                 rsp_o
);
  import bba_pkg::*;

  logic [ByteW-1:0] byte_limit_q;

  // input stage
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [ByteW-1:0] s1_delta_q;
  logic             s1_grow_q;
  logic             s1_amt_zero_q;
  logic [ByteW-1:0] s1_amount_q;
  logic [ByteW-1:0] s1_held_q;
  logic             s1_held_ov_q;
  logic             s1_allow_q;

  // budget state
  logic [ByteW-1:0] tot_lo_q, tot_lo_d;
  logic             tot_hi_q, tot_hi_d;
  logic [ByteW-1:0] peak_q, peak_d;
  logic             ovr_q, ovr_d;
  logic             canc_q, canc_d;

  // result register
  logic             rsp_valid_q;
  status_e          status_q, status_d;
  logic [ByteW-1:0] new_bytes_q, new_bytes_d;
  logic             new_ov_q, new_ov_d;

  logic             adv;
  logic             take;
  logic [ByteW:0]   up_diff;
  logic [ByteW:0]   dn_diff;

  assign adv          = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready  = !s1_valid_q || !rsp_valid_q || rsp_o.ready;
  assign take         = req_i.valid && req_i.ready;

  // amount - held: a borrow or a zero result means shrink (or equal)
  assign up_diff = {1'b0, req_i.amount} - {1'b0, req_i.held_bytes};
  assign dn_diff = {1'b0, req_i.held_bytes} - {1'b0, req_i.amount};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      byte_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_op_q       <= op_e'(req_i.op);
      s1_amount_q   <= req_i.amount;
      s1_held_q     <= req_i.held_bytes;
      s1_held_ov_q  <= req_i.held_overage;
      s1_allow_q    <= req_i.allow_overage;
      s1_amt_zero_q <= (req_i.amount == '0);
      s1_grow_q     <= 1'b0;
      s1_delta_q    <= req_i.amount;
      if (op_e'(req_i.op) == OP_RESIZE) begin
        if (up_diff[ByteW] || up_diff[ByteW-1:0] == '0) begin
          s1_delta_q <= dn_diff[ByteW-1:0];
        end else begin
          s1_grow_q  <= 1'b1;
          s1_delta_q <= up_diff[ByteW-1:0];
        end
      end
    end
  end

  // evaluation of the captured request against the current state
  logic [ByteW-1:0] headroom;
  logic             fit_lim;
  logic             fits;
  logic [ByteW:0]   sum;
  logic [ByteW:0]   diff;
  logic [ByteW-1:0] add_lo, sub_lo, add_peak;
  logic             add_hi, sub_hi;
  logic             fit_after_sub;

  always_comb begin
    headroom = byte_limit_q - tot_lo_q;
    fit_lim  = !tot_hi_q && (tot_lo_q <= byte_limit_q);
    fits     = fit_lim && (s1_delta_q <= headroom);
    sum      = {1'b0, tot_lo_q} + {1'b0, s1_delta_q};
    diff     = {1'b0, tot_lo_q} - {1'b0, s1_delta_q};

    if (tot_hi_q) begin
      add_lo   = sum[ByteW] ? AllOnes : sum[ByteW-1:0];
      add_hi   = 1'b1;
      add_peak = AllOnes;
    end else if (sum[ByteW]) begin
      add_lo   = sum[ByteW-1:0];
      add_hi   = 1'b1;
      add_peak = AllOnes;
    end else begin
      add_lo   = sum[ByteW-1:0];
      add_hi   = 1'b0;
      add_peak = (sum[ByteW-1:0] > peak_q) ? sum[ByteW-1:0] : peak_q;
    end

    // borrow out of the low word clears the high bit; without the high bit the total clamps at zero
    if (tot_hi_q) begin
      sub_lo = diff[ByteW-1:0];
      sub_hi = !diff[ByteW];
    end else begin
      sub_lo = diff[ByteW] ? '0 : diff[ByteW-1:0];
      sub_hi = 1'b0;
    end
    fit_after_sub = !sub_hi && (sub_lo <= byte_limit_q);

    tot_lo_d    = tot_lo_q;
    tot_hi_d    = tot_hi_q;
    peak_d      = peak_q;
    ovr_d       = ovr_q;
    canc_d      = canc_q;
    status_d    = ST_DONE;
    new_bytes_d = '0;
    new_ov_d    = 1'b0;

    case (s1_op_q)
      OP_ACQUIRE: begin
        if (canc_q) begin
          status_d = ST_CANCELLED;
        end else if (!s1_amt_zero_q) begin
          if (fits || (s1_allow_q && !ovr_q)) begin
            tot_lo_d    = add_lo;
            tot_hi_d    = add_hi;
            peak_d      = add_peak;
            new_bytes_d = s1_amount_q;
            new_ov_d    = !fits;
            if (!fits) begin
              ovr_d = 1'b1;
            end
          end else begin
            status_d = ST_WAIT;
          end
        end
      end
      OP_RESIZE: begin
        new_bytes_d = s1_held_q;
        new_ov_d    = s1_held_ov_q;
        if (canc_q) begin
          status_d = ST_CANCELLED;
        end else if (!s1_grow_q) begin
          tot_lo_d    = sub_lo;
          tot_hi_d    = sub_hi;
          new_bytes_d = s1_amount_q;
          if (s1_held_ov_q && fit_after_sub) begin
            new_ov_d = 1'b0;
            ovr_d    = 1'b0;
          end
        end else if (fits || (s1_allow_q && (s1_held_ov_q || !ovr_q))) begin
          tot_lo_d    = add_lo;
          tot_hi_d    = add_hi;
          peak_d      = add_peak;
          new_bytes_d = s1_amount_q;
          if (fits) begin
            if (s1_held_ov_q) begin
              new_ov_d = 1'b0;
              ovr_d    = 1'b0;
            end
          end else if (!s1_held_ov_q) begin
            new_ov_d = 1'b1;
            ovr_d    = 1'b1;
          end
        end else begin
          status_d = ST_WAIT;
        end
      end
      OP_RELEASE: begin
        tot_lo_d = sub_lo;
        tot_hi_d = sub_hi;
        if (s1_held_ov_q) begin
          ovr_d = 1'b0;
        end
      end
      OP_CANCEL: begin
        canc_d = 1'b1;
      end
      default: begin
        canc_d = canc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_lo_q    <= '0;
      tot_hi_q    <= 1'b0;
      peak_q      <= '0;
      ovr_q       <= 1'b0;
      canc_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else if (adv) begin
      tot_lo_q    <= tot_lo_d;
      tot_hi_q    <= tot_hi_d;
      peak_q      <= peak_d;
      ovr_q       <= ovr_d;
      canc_q      <= canc_d;
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q    <= status_d;
      new_bytes_q <= new_bytes_d;
      new_ov_q    <= new_ov_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.new_bytes   = new_bytes_q;
  assign rsp_o.new_overage = new_ov_q;
  assign rsp_o.total_bytes = tot_hi_q ? AllOnes : tot_lo_q;
  assign rsp_o.peak_total  = peak_q;

endmodule

// ----- tb/bba_checker.sv -----
module bba_checker
  import bba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  bba_req_if               req_i,
  bba_rsp_if               rsp_i,
  output int unsigned      pending_o,
  output int unsigned      faults_o,
  output int unsigned      checked_o
);

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] new_bytes;
    logic             new_overage;
    logic [ByteW-1:0] total;
    logic [ByteW-1:0] peak;
  } verdict_t;

  // shadow of the budget: 65-bit total split into low word and carry bit
  logic [ByteW-1:0] limit = LimitReset;
  logic [ByteW-1:0] sum_lo = '0;
  logic             sum_hi = 1'b0;
  logic [ByteW-1:0] peak = '0;
  logic             overage_busy = 1'b0;
  logic             cancelled = 1'b0;
  verdict_t         owed_q[$];

  function automatic logic fits_under_limit(logic [ByteW-1:0] extra);
    return !sum_hi && sum_lo <= limit && extra <= limit - sum_lo;
  endfunction

  function automatic void charge(logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, sum_lo} + {1'b0, b};
    if (sum_hi) begin
      sum_lo = s[ByteW] ? AllOnes : s[ByteW-1:0];
      peak   = AllOnes;
    end else if (s[ByteW]) begin
      sum_lo = s[ByteW-1:0];
      sum_hi = 1'b1;
      peak   = AllOnes;
    end else begin
      sum_lo = s[ByteW-1:0];
      if (sum_lo > peak) peak = sum_lo;
    end
  endfunction

  function automatic void refund(logic [ByteW-1:0] b);
    if (sum_hi) begin
      // borrow out of the low word takes the carry bit
      if (b > sum_lo) sum_hi = 1'b0;
      sum_lo = sum_lo - b;
    end else begin
      sum_lo = (b > sum_lo) ? '0 : sum_lo - b;
    end
  endfunction

  function automatic verdict_t admit(op_e op, logic [ByteW-1:0] amount,
                                     logic [ByteW-1:0] held, logic held_ov, logic allow);
    verdict_t         v;
    logic             fit;
    logic [ByteW-1:0] extra;
    v.status      = ST_DONE;
    v.new_bytes   = '0;
    v.new_overage = 1'b0;
    case (op)
      OP_ACQUIRE: begin
        if (cancelled) begin
          v.status = ST_CANCELLED;
        end else if (amount != '0) begin
          fit = fits_under_limit(amount);
          if (fit || (allow && !overage_busy)) begin
            charge(amount);
            if (!fit) overage_busy = 1'b1;
            v.new_bytes   = amount;
            v.new_overage = !fit;
          end else begin
            v.status = ST_WAIT;
          end
        end
      end
      OP_RESIZE: begin
        v.new_bytes   = held;
        v.new_overage = held_ov;
        if (cancelled) begin
          v.status = ST_CANCELLED;
        end else if (amount <= held) begin
          refund(held - amount);
          v.new_bytes = amount;
          if (held_ov && fits_under_limit('0)) begin
            v.new_overage = 1'b0;
            overage_busy  = 1'b0;
          end
        end else begin
          extra = amount - held;
          fit   = fits_under_limit(extra);
          // the permit already holding the overage may keep growing on it
          if (fit || (allow && (held_ov || !overage_busy))) begin
            charge(extra);
            v.new_bytes = amount;
            if (fit) begin
              if (held_ov) begin
                v.new_overage = 1'b0;
                overage_busy  = 1'b0;
              end
            end else if (!held_ov) begin
              v.new_overage = 1'b1;
              overage_busy  = 1'b1;
            end
          end else begin
            v.status = ST_WAIT;
          end
        end
      end
      OP_RELEASE: begin
        refund(amount);
        if (held_ov) overage_busy = 1'b0;
      end
      OP_CANCEL: begin
        cancelled = 1'b1;
      end
      default: ;
    endcase
    v.total = sum_hi ? AllOnes : sum_lo;
    v.peak  = peak;
    return v;
  endfunction

  task automatic report_fault(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    faults_o++;
  endtask

  task automatic compare_field(string field, logic [ByteW-1:0] got, logic [ByteW-1:0] want);
    if (got !== want)
      report_fault($sformatf("result %0d %s: got %h, want %h", checked_o, field, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      limit        = LimitReset;
      sum_lo       = '0;
      sum_hi       = 1'b0;
      peak         = '0;
      overage_busy = 1'b0;
      cancelled    = 1'b0;
      owed_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) limit = cfg_wdata_i;
      // retire before admitting: a result never belongs to a request of the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_q.size() == 0) begin
          report_fault("result transfer with no request outstanding");
        end else begin
          want = owed_q.pop_front();
          compare_field("status", rsp_i.status, want.status);
          compare_field("new_bytes", rsp_i.new_bytes, want.new_bytes);
          compare_field("new_overage", rsp_i.new_overage, want.new_overage);
          compare_field("total_bytes", rsp_i.total_bytes, want.total);
          compare_field("peak_total", rsp_i.peak_total, want.peak);
          checked_o++;
        end
      end
      if (req_i.valid && req_i.ready)
        owed_q.push_back(admit(op_e'(req_i.op), req_i.amount, req_i.held_bytes,
                               req_i.held_overage, req_i.allow_overage));
      pending_o <= owed_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import bba_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 110;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ByteW-1:0] cfg_wdata_i;

  int unsigned      pending;
  int unsigned      faults;
  int unsigned      checked;
  int unsigned      cycles = 0;
  int unsigned      stall_left = 0;
  int unsigned      sent_by_op[4];
  int unsigned      limits_used = 1;
  bit               quiet = 1'b0;
  logic [ByteW-1:0] limit_now = LimitReset;
  logic [ByteW-1:0] recent_sizes[$];

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  byte_budget_admission uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  bba_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .pending_o  (pending),
    .faults_o   (faults),
    .checked_o  (checked)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("byte_budget_admission test failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // result side: after each transfer, hold ready low for a drawn number of cycles
  always @(posedge clk_i) begin
    int unsigned w;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_if.ready <= (stall_left == 1);
    end else if (rsp_if.valid && rsp_if.ready) begin
      w = draw_wait();
      stall_left   <= w;
      rsp_if.ready <= (w == 0);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  function automatic logic [ByteW-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 64'($urandom_range(1, 64));
      2:       return limit_now >> $urandom_range(0, 6);
      3:       return limit_now - $urandom_range(0, 3);
      4:       return limit_now + $urandom_range(1, 3);
      5:       return AllOnes - $urandom_range(0, 7);
      6:       return {$urandom, $urandom};
      default: return {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
  endfunction

  // a size some permit was recently asked for, so resizes and releases look plausible
  function automatic logic [ByteW-1:0] recall_size();
    if (recent_sizes.size() == 0) return pick_size();
    return recent_sizes[$urandom_range(0, recent_sizes.size() - 1)];
  endfunction

  task automatic send_req(op_e op, logic [ByteW-1:0] amount, logic [ByteW-1:0] held,
                          logic held_ov, logic allow);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= op;
    req_if.amount        <= amount;
    req_if.held_bytes    <= held;
    req_if.held_overage  <= held_ov;
    req_if.allow_overage <= allow;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_by_op[op]++;
    if ((op == OP_ACQUIRE || op == OP_RESIZE) && amount != '0) begin
      recent_sizes.push_back(amount);
      if (recent_sizes.size() > 16) void'(recent_sizes.pop_front());
    end
    if ($urandom_range(0, 39) == 0) quiet <= !quiet;
  endtask

  task automatic random_request();
    int unsigned      pick;
    op_e              op;
    logic [ByteW-1:0] amt;
    logic [ByteW-1:0] held;
    logic             hov;
    logic             allow;
    pick  = $urandom_range(0, 99);
    hov   = ($urandom_range(0, 3) == 0);
    allow = 1'($urandom_range(0, 1));
    held  = {$urandom, $urandom};
    if (pick < 8) begin
      // noise: fields unrelated to any permit
      op  = op_e'($urandom_range(0, 2));
      amt = {$urandom, $urandom};
      hov = 1'($urandom_range(0, 1));
    end else if (pick < 48) begin
      op  = OP_ACQUIRE;
      amt = pick_size();
    end else if (pick < 78) begin
      op   = OP_RESIZE;
      held = recall_size();
      case ($urandom_range(0, 3))
        0:       amt = held - $urandom_range(0, 255);
        1:       amt = held + $urandom_range(1, 255);
        2:       amt = pick_size();
        default: amt = held;
      endcase
    end else begin
      op  = OP_RELEASE;
      amt = recall_size();
    end
    send_req(op, amt, held, hov, allow);
  endtask

  task automatic drain(int unsigned settle);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [ByteW-1:0] value);
    drain(3);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    limit_now = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limits_used++;
  endtask

  initial begin
    logic [ByteW-1:0] phase_limits[5];
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.op            = OP_ACQUIRE;
    req_if.amount        = '0;
    req_if.held_bytes    = '0;
    req_if.held_overage  = 1'b0;
    req_if.allow_overage = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, with the limit at its reset value
    send_req(OP_ACQUIRE, '0, AllOnes, 1'b1, 1'b1);        // zero-byte acquire
    send_req(OP_ACQUIRE, LimitReset, '0, 1'b0, 1'b0);     // fills the limit exactly
    send_req(OP_ACQUIRE, 64'd1, '0, 1'b0, 1'b0);          // no room, no overage: wait
    send_req(OP_ACQUIRE, 64'd1, '0, 1'b0, 1'b1);          // granted as overage
    send_req(OP_ACQUIRE, 64'd5, '0, 1'b0, 1'b1);          // overage taken: wait
    send_req(OP_RESIZE, LimitReset + 1, LimitReset, 1'b0, 1'b1);
    send_req(OP_RESIZE, 64'd100, 64'd1, 1'b1, 1'b1);      // overage holder grows
    send_req(OP_RESIZE, '0, 64'd100, 1'b1, 1'b0);         // shrink back under, overage freed
    send_req(OP_RELEASE, LimitReset, '0, 1'b0, 1'b0);
    send_req(OP_RELEASE, AllOnes, '0, 1'b0, 1'b0);        // clamps at zero
    send_req(OP_ACQUIRE, AllOnes, '0, 1'b0, 1'b1);
    send_req(OP_ACQUIRE, AllOnes, '0, 1'b0, 1'b1);
    send_req(OP_RESIZE, AllOnes, 64'd5, 1'b1, 1'b1);      // carries into the high bit
    send_req(OP_ACQUIRE, 64'd3, '0, 1'b0, 1'b0);
    send_req(OP_RELEASE, '0, '0, 1'b1, 1'b0);             // frees overage only
    send_req(OP_ACQUIRE, AllOnes, '0, 1'b0, 1'b1);        // low word saturates
    send_req(OP_RELEASE, AllOnes, '0, 1'b1, 1'b0);        // high bit survives
    send_req(OP_RELEASE, 64'd1, '0, 1'b0, 1'b0);          // borrow clears high bit
    send_req(OP_RESIZE, '0, AllOnes, 1'b0, 1'b0);
    send_req(OP_RESIZE, 64'd7, 64'd7, 1'b0, 1'b0);
    send_req(OP_RESIZE, 64'd4096, '0, 1'b0, 1'b0);
    send_req(OP_RESIZE, 64'd8192, 64'd4096, 1'b1, 1'b0);

    phase_limits = '{64'd1000, AllOnes, 64'd1, {$urandom, $urandom} | 64'd1,
                     64'h8000_0000_0000_0000};
    foreach (phase_limits[i]) begin
      set_limit(phase_limits[i]);
      repeat (PhaseItems) random_request();
    end

    // cancel is terminal, so it comes last
    send_req(OP_CANCEL, {$urandom, $urandom}, AllOnes, 1'b1, 1'b1);
    send_req(OP_ACQUIRE, 64'd1, '0, 1'b0, 1'b1);
    send_req(OP_RESIZE, 64'd50, 64'd10, 1'b1, 1'b1);
    send_req(OP_RESIZE, 64'd2, 64'd10, 1'b1, 1'b0);
    send_req(OP_RELEASE, 64'd10, '0, 1'b1, 1'b0);
    send_req(OP_CANCEL, '0, '0, 1'b0, 1'b0);
    repeat (10) random_request();

    drain(6);
    $display("Ran %0d acquires, %0d resizes, %0d releases and %0d cancels under %0d limits;",
             sent_by_op[OP_ACQUIRE], sent_by_op[OP_RESIZE], sent_by_op[OP_RELEASE],
             sent_by_op[OP_CANCEL], limits_used);
    $display("%0d results compared against the predicted budget state.", checked);
    if (faults == 0) begin
      $display("byte_budget_admission test passed");
    end else begin
      $display("byte_budget_admission test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/byte_budget_admission.sv
tb/bba_checker.sv
tb/testbench.sv
